FILE: sv/frt_pkg.sv
// Package: constants, codes and entry record type for the fragment reassembly tracker.
`default_nettype none
package frt_pkg;
  localparam int unsigned FRT_TABLE_ENTRIES = 8;
  localparam int unsigned FRT_MAX_SEQUENCES = 256;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_MIDDLE = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_SINGLE = 3'd3;

  localparam logic [2:0] STAT_STORED   = 3'd0;
  localparam logic [2:0] STAT_COMPLETE = 3'd1;
  localparam logic [2:0] STAT_SINGLE   = 3'd2;
  localparam logic [2:0] STAT_BAD      = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef struct packed {
    logic [7:0]  lowest_seq;
    logic        lowest_is_start;
    logic [7:0]  highest_seq;
    logic        highest_is_finished;
    logic [8:0]  seen_count;
    logic [15:0] length_sum;
  } frt_info_t;
endpackage
`default_nettype wire

FILE: sv/fragment_reassembly_tracker.sv
// Fragment reassembly tracker: per-key fragment bookkeeping held in two table memories.
//
// Input channel in_*: one fragment header per request (key, sequence, kind, length).
// Result channel out_*: exactly one result per request, in order.
// Key lookup runs over the valid/key flip-flops when a request is taken and launches a
// read of the entry record and its seen-sequence row (one memory row per entry).
// The work state then modifies the record, writes it back for a stored fragment and loads
// the output register, waiting there until the output register is free. A new request is
// taken only once the previous one has left the work state. A result may wait in the output
// register while the next request is taken; the write-back of that next request holds until
// the output register frees.
// An allocated entry gets a fresh seen row, so freeing needs no clearing pass.
// Reset (rst_n low, synchronous) invalidates all entries and empties the output.
// Memory contents are not reset.
`default_nettype none
module fragment_reassembly_tracker #(
  parameter int unsigned TABLE_ENTRIES = frt_pkg::FRT_TABLE_ENTRIES,
  parameter int unsigned MAX_SEQUENCES = frt_pkg::FRT_MAX_SEQUENCES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_frag_key,
  input  wire logic [7:0]  in_frag_sequence,
  input  wire logic [2:0]  in_frag_kind,
  input  wire logic [15:0] in_frag_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_done_key,
  output logic [15:0]      out_total_length,
  output logic [7:0]       out_first_sequence,
  output logic [8:0]       out_fragment_count
);
  import frt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SEQ_W = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;
  localparam logic [8:0]  MAX_SEQ_V = 9'(MAX_SEQUENCES);
  localparam logic        ST_IDLE = 1'b0;
  localparam logic        ST_WORK = 1'b1;

  logic                     state_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              key_tab_r [TABLE_ENTRIES];

  frt_info_t                info_mem [TABLE_ENTRIES];
  logic [MAX_SEQUENCES-1:0] seen_mem [TABLE_ENTRIES];
  frt_info_t                info_rd_r;
  logic [MAX_SEQUENCES-1:0] seen_rd_r;

  logic [31:0]      key_r;
  logic [7:0]       seq_r;
  logic [2:0]       kind_r;
  logic [15:0]      len_r;
  logic [IDX_W-1:0] idx_r;
  logic             single_r, bad_r, full_r, new_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_key_r;
  logic [15:0] out_len_r;
  logic [7:0]  out_first_r;
  logic [8:0]  out_count_r;

  logic             accept, out_free, advance;
  logic             hit_found, spare_found;
  logic [IDX_W-1:0] hit_idx, spare_idx;
  logic             bad_in;

  always_comb begin
    hit_found   = 1'b0;
    spare_found = 1'b0;
    hit_idx     = '0;
    spare_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_tab_r[i] == in_frag_key) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        spare_found = 1'b1;
        spare_idx   = IDX_W'(i);
      end
    end
  end

  assign bad_in   = (in_frag_kind > KIND_SINGLE) || (in_frag_sequence == 8'd0) ||
                    ({1'b0, in_frag_sequence} >= MAX_SEQ_V);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign advance  = (state_r == ST_WORK) && out_free;

  // Request capture and memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= in_frag_key;
      seq_r    <= in_frag_sequence;
      kind_r   <= in_frag_kind;
      len_r    <= in_frag_length;
      single_r <= (in_frag_kind == KIND_SINGLE);
      bad_r    <= bad_in && (in_frag_kind != KIND_SINGLE);
      full_r   <= !hit_found && !spare_found;
      new_r    <= !hit_found;
      idx_r    <= hit_found ? hit_idx : spare_idx;
      info_rd_r <= info_mem[hit_found ? hit_idx : spare_idx];
      seen_rd_r <= seen_mem[hit_found ? hit_idx : spare_idx];
    end
  end

  // Modify
  logic [MAX_SEQUENCES-1:0] seq_bit;
  logic                     seen_dup, frag_ok, complete, do_write;
  frt_info_t                info_nxt;
  logic [8:0]               span;
  logic [2:0]               status_nxt;
  logic [15:0]              len_nxt;
  logic [7:0]               first_nxt;
  logic [8:0]               count_nxt;

  always_comb begin
    seq_bit  = '0;
    seq_bit[seq_r[SEQ_W-1:0]] = 1'b1;
    seen_dup = !new_r && seen_rd_r[seq_r[SEQ_W-1:0]];
    frag_ok  = !single_r && !bad_r && !full_r && !seen_dup;
    if (new_r) begin
      info_nxt.lowest_seq          = seq_r;
      info_nxt.lowest_is_start     = (kind_r == KIND_START);
      info_nxt.highest_seq         = seq_r;
      info_nxt.highest_is_finished = (kind_r == KIND_FINISH);
      info_nxt.seen_count          = 9'd1;
      info_nxt.length_sum          = len_r;
    end else begin
      info_nxt = info_rd_r;
      if (seq_r < info_rd_r.lowest_seq) begin
        info_nxt.lowest_seq      = seq_r;
        info_nxt.lowest_is_start = (kind_r == KIND_START);
      end
      if (seq_r > info_rd_r.highest_seq) begin
        info_nxt.highest_seq         = seq_r;
        info_nxt.highest_is_finished = (kind_r == KIND_FINISH);
      end
      info_nxt.seen_count = info_rd_r.seen_count + 9'd1;
      info_nxt.length_sum = info_rd_r.length_sum + len_r;
    end
    span     = {1'b0, info_nxt.highest_seq} - {1'b0, info_nxt.lowest_seq} + 9'd1;
    complete = frag_ok && info_nxt.lowest_is_start && info_nxt.highest_is_finished &&
               (info_nxt.seen_count >= 9'd2) && (span == info_nxt.seen_count);
    do_write = advance && frag_ok && !complete;

    status_nxt = STAT_STORED;
    len_nxt    = '0;
    first_nxt  = '0;
    count_nxt  = '0;
    if (single_r) begin
      status_nxt = STAT_SINGLE;
      len_nxt    = len_r;
      first_nxt  = seq_r;
      count_nxt  = 9'd1;
    end else if (bad_r) begin
      status_nxt = STAT_BAD;
    end else if (full_r) begin
      status_nxt = STAT_FULL;
    end else if (complete) begin
      status_nxt = STAT_COMPLETE;
      len_nxt    = info_nxt.length_sum;
      first_nxt  = info_nxt.lowest_seq;
      count_nxt  = info_nxt.seen_count;
    end
  end

  // Write-back
  always_ff @(posedge clk) begin
    if (do_write) begin
      info_mem[idx_r]  <= info_nxt;
      seen_mem[idx_r]  <= new_r ? seq_bit : (seen_rd_r | seq_bit);
      key_tab_r[idx_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !advance) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (advance) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            if (do_write) begin
              valid_r[idx_r] <= 1'b1;
            end
            if (complete) begin
              valid_r[idx_r] <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_key_r    <= key_r;
      out_len_r    <= len_nxt;
      out_first_r  <= first_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_done_key       = out_key_r;
  assign out_total_length   = out_len_r;
  assign out_first_sequence = out_first_r;
  assign out_fragment_count = out_count_r;
endmodule
`default_nettype wire
